/* rtl/ifdc_pkg.sv */
package ifdc_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BCC_ERR = 2'd2;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_FLAG    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ESCAPE  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_MASK    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ADDRESS = 3'd3;
    localparam logic [INDEX_W-1:0] REG_CTRL0   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_CTRL1   = 3'd5;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_FLAG    = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'h7D;
    localparam logic [BYTE_W-1:0] RST_MASK    = 8'h20;
    localparam logic [BYTE_W-1:0] RST_ADDRESS = 8'h03;
    localparam logic [BYTE_W-1:0] RST_CTRL0   = 8'h00;
    localparam logic [BYTE_W-1:0] RST_CTRL1   = 8'h40;
    localparam logic [BYTE_W-1:0] XOR_INIT    = 8'h00;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_BCC1 = 3'd3,
        PH_BODY = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] address_value;
        logic [BYTE_W-1:0] ctrl_seq0;
        logic [BYTE_W-1:0] ctrl_seq1;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              seq_number;
        logic              reply_is_reject;
        logic              reply_number;
    } result_t;

endpackage

/* rtl/ifdc_cfg.sv */
module ifdc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [ifdc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ifdc_pkg::BYTE_W-1:0]   cfg_data,
    output ifdc_pkg::cfg_t                cfg
);
    import ifdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FLAG:    cfg_next.flag_value    = cfg_data;
                REG_ESCAPE:  cfg_next.escape_value  = cfg_data;
                REG_MASK:    cfg_next.stuff_mask    = cfg_data;
                REG_ADDRESS: cfg_next.address_value = cfg_data;
                REG_CTRL0:   cfg_next.ctrl_seq0     = cfg_data;
                REG_CTRL1:   cfg_next.ctrl_seq1     = cfg_data;
                default:     cfg_next = cfg_reg;  // unused indexes are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_value    <= RST_FLAG;
            cfg_reg.escape_value  <= RST_ESCAPE;
            cfg_reg.stuff_mask    <= RST_MASK;
            cfg_reg.address_value <= RST_ADDRESS;
            cfg_reg.ctrl_seq0     <= RST_CTRL0;
            cfg_reg.ctrl_seq1     <= RST_CTRL1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ifdc_core.sv */
module ifdc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [ifdc_pkg::BYTE_W-1:0] rx_byte,
    input  ifdc_pkg::cfg_t              cfg,
    output logic                        res_valid,
    output ifdc_pkg::result_t           res
);
    import ifdc_pkg::*;

    phase_t            phase_reg,      phase_next;
    logic              seq_reg,        seq_next;
    logic              esc_reg,        esc_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] held_reg,       held_next;
    logic [BYTE_W-1:0] xor_reg,        xor_next;

    logic              is_flag;
    logic              is_escape;
    logic [BYTE_W-1:0] ctrl_sel;
    logic [BYTE_W-1:0] body_value;
    logic              body_take;

    assign is_flag   = (rx_byte == cfg.flag_value);
    assign is_escape = (rx_byte == cfg.escape_value);
    assign ctrl_sel  = seq_reg ? cfg.ctrl_seq1 : cfg.ctrl_seq0;

    // a body byte lands in the hold register unless it is a flag or a fresh escape
    assign body_take  = !is_flag && (esc_reg || !is_escape);
    assign body_value = esc_reg ? (rx_byte ^ cfg.stuff_mask) : rx_byte;

    // next state
    always_comb begin
        phase_next      = phase_reg;
        seq_next        = seq_reg;
        esc_next        = esc_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        xor_next        = xor_reg;
        if (step_en) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (rx_byte == cfg.address_value) begin
                        phase_next = PH_CTRL;
                    end else if (!is_flag) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CTRL: begin
                    if (rx_byte == cfg.ctrl_seq0) begin
                        seq_next   = 1'b0;
                        phase_next = PH_BCC1;
                    end else if (rx_byte == cfg.ctrl_seq1) begin
                        seq_next   = 1'b1;
                        phase_next = PH_BCC1;
                    end else if (is_flag) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BCC1: begin
                    if (rx_byte == (cfg.address_value ^ ctrl_sel)) begin
                        esc_next        = 1'b0;
                        held_valid_next = 1'b0;
                        held_next       = '0;
                        xor_next        = XOR_INIT;
                        phase_next      = PH_BODY;
                    end else if (is_flag) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (is_flag) begin
                        esc_next = 1'b0;
                        if (held_valid_reg) begin
                            // closing flag doubles as the next opening flag
                            held_valid_next = 1'b0;
                            held_next       = '0;
                            xor_next        = XOR_INIT;
                            phase_next      = PH_ADDR;
                        end
                    end else if (body_take) begin
                        esc_next        = 1'b0;
                        held_next       = body_value;
                        held_valid_next = 1'b1;
                        if (held_valid_reg) begin
                            xor_next = xor_reg ^ held_reg;
                        end
                    end else begin
                        esc_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = is_flag ? PH_ADDR : PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        res_valid           = 1'b0;
        res.out_kind        = KIND_DATA;
        res.data_byte       = '0;
        res.seq_number      = seq_reg;
        res.reply_is_reject = 1'b0;
        res.reply_number    = 1'b0;
        if (step_en && phase_reg == PH_BODY && held_valid_reg) begin
            if (is_flag) begin
                res_valid = 1'b1;
                if (held_reg == xor_reg) begin
                    res.out_kind     = KIND_GOOD;
                    res.reply_number = !seq_reg;
                end else begin
                    res.out_kind        = KIND_BCC_ERR;
                    res.reply_is_reject = 1'b1;
                    res.reply_number    = seq_reg;
                end
            end else if (body_take) begin
                res_valid     = 1'b1;
                res.data_byte = held_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            seq_reg        <= 1'b0;
            esc_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            xor_reg        <= XOR_INIT;
        end else begin
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            esc_reg        <= esc_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            xor_reg        <= xor_next;
        end
    end

endmodule

/* rtl/ifdc_out_reg.sv */
module ifdc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              res_valid,
    input  ifdc_pkg::result_t res,
    input  logic              m_axis_tready,
    output logic              free,
    output logic              m_axis_tvalid,
    output ifdc_pkg::result_t m_res
);
    import ifdc_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg,   res_next;

    // register can take a new result when empty or drained this cycle
    assign free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (free) begin
            valid_next = load && res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_res         = res_reg;

endmodule

/* rtl/info_frame_deframer_checker.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[10:0] data/seq/reply, tuser kind
// cfg       in   cfg_valid/cfg_ready            cfg_index[2:0], cfg_data[7:0]
//
// One byte per cycle sustained while the output is not stalled. A byte is first
// held in the input register, then the frame state updates and any result lands
// in the output register. Reset is synchronous, active low, and returns the valid
// flags, configuration and frame state to their reset values. A stalled output
// holds its result; once the input register is also full, s_axis_tready drops
// until the output register drains.
module info_frame_deframer_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [7:0] data_byte, [8] seq_number,
                                                         // [9] reply_is_reject,
                                                         // [10] reply_number, rest 0
    output logic [1:0]                   m_axis_tuser,   // [1:0] out_kind
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ifdc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [ifdc_pkg::BYTE_W-1:0]  cfg_data
);
    import ifdc_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,  in_byte_next;
    logic              step_en;
    logic              out_free;
    logic              res_valid;
    result_t           res;
    result_t           m_res;

    assign cfg_ready = 1'b1;

    ifdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    assign step_en       = in_valid_reg && out_free;
    assign s_axis_tready = out_free || !in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
    end

    ifdc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    ifdc_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step_en),
        .res_valid     (res_valid),
        .res           (res),
        .m_axis_tready (m_axis_tready),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_res         (m_res)
    );

    assign m_axis_tdata = {5'b0, m_res.reply_number, m_res.reply_is_reject,
                           m_res.seq_number, m_res.data_byte};
    assign m_axis_tuser = m_res.out_kind;

endmodule

/* rtl/ifdc_checker.sv */
module ifdc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [15:0]                  m_axis_tdata,
    input logic [1:0]                   m_axis_tuser
);
    import ifdc_pkg::*;

    // out of reset the result register is empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // data transfers carry no reply bits
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_DATA |-> m_axis_tdata[10:9] == 2'b00)
        else $error("reply bits set on a data transfer");

    // frame-end reply matches the verdict and sequence bit
    a_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |->
            m_axis_tdata[7:0] == 8'h00 &&
            ((m_axis_tuser == KIND_GOOD && !m_axis_tdata[9] &&
              m_axis_tdata[10] != m_axis_tdata[8]) ||
             (m_axis_tuser == KIND_BCC_ERR && m_axis_tdata[9] &&
              m_axis_tdata[10] == m_axis_tdata[8])))
        else $error("bad frame-end report");

    // a result into an empty output register comes from a byte accepted earlier,
    // registered in the input register and then stepped through the frame state
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a cause");

endmodule

bind info_frame_deframer_checker ifdc_checker u_ifdc_checker (.*);

/* tb/tb_info_frame_deframer_checker.sv */
`timescale 1ns / 1ps

module tb_info_frame_deframer_checker;
    import ifdc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_BYTES    = 150;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam result_t NO_RESULT = '0;

    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        result_t    want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]   cfg_data;

    info_frame_deframer_checker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 aclk = ~aclk;

    // receiver model state
    cfg_t       rx_cfg = '{RST_FLAG, RST_ESCAPE, RST_MASK, RST_ADDRESS, RST_CTRL0, RST_CTRL1};
    phase_t     rx_phase = PH_HUNT;
    logic       rx_seq = 1'b0;
    logic       rx_escape = 1'b0;
    logic       rx_held_valid = 1'b0;
    logic [7:0] rx_held = 8'h00;
    logic [7:0] rx_xor = XOR_INIT;

    result_t    frame_results_due [$];
    stim_row_t  rx_pins [$];
    logic [7:0] line_bytes [$];
    stim_row_t  directed_rows [30];

    int mismatch_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;

    function automatic void clear_body();
        rx_escape = 1'b0;
        rx_held_valid = 1'b0;
        rx_held = 8'h00;
        rx_xor = XOR_INIT;
    endfunction

    // one received byte through the deframer; returns 1 when a result comes out
    function automatic logic deframe_rx(input logic [7:0] b, output result_t r);
        logic [7:0] ctrl;
        logic [7:0] value;
        logic       take;
        logic       emit;
        emit = 1'b0;
        take = 1'b0;
        value = b;
        r = NO_RESULT;
        case (rx_phase)
            PH_ADDR: begin
                if (b == rx_cfg.address_value)
                    rx_phase = PH_CTRL;
                else if (b != rx_cfg.flag_value)
                    rx_phase = PH_HUNT;
            end
            PH_CTRL: begin
                if (b == rx_cfg.ctrl_seq0) begin
                    rx_seq = 1'b0;
                    rx_phase = PH_BCC1;
                end else if (b == rx_cfg.ctrl_seq1) begin
                    rx_seq = 1'b1;
                    rx_phase = PH_BCC1;
                end else if (b == rx_cfg.flag_value) begin
                    rx_phase = PH_ADDR;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_BCC1: begin
                ctrl = rx_seq ? rx_cfg.ctrl_seq1 : rx_cfg.ctrl_seq0;
                if (b == (rx_cfg.address_value ^ ctrl)) begin
                    clear_body();
                    rx_phase = PH_BODY;
                end else if (b == rx_cfg.flag_value) begin
                    rx_phase = PH_ADDR;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                if (b == rx_cfg.flag_value) begin
                    if (rx_held_valid) begin
                        emit = 1'b1;
                        r.seq_number = rx_seq;
                        if (rx_held == rx_xor) begin
                            r.out_kind = KIND_GOOD;
                            r.reply_number = ~rx_seq;
                        end else begin
                            r.out_kind = KIND_BCC_ERR;
                            r.reply_is_reject = 1'b1;
                            r.reply_number = rx_seq;
                        end
                        clear_body();
                        rx_phase = PH_ADDR;
                    end else begin
                        rx_escape = 1'b0;
                    end
                end else if (rx_escape) begin
                    value = b ^ rx_cfg.stuff_mask;
                    rx_escape = 1'b0;
                    take = 1'b1;
                end else if (b == rx_cfg.escape_value) begin
                    rx_escape = 1'b1;
                end else begin
                    take = 1'b1;
                end
                if (take) begin
                    if (rx_held_valid) begin
                        emit = 1'b1;
                        r.out_kind = KIND_DATA;
                        r.data_byte = rx_held;
                        r.seq_number = rx_seq;
                        rx_xor = rx_xor ^ rx_held;
                    end
                    rx_held = value;
                    rx_held_valid = 1'b1;
                end
            end
            default: rx_phase = (b == rx_cfg.flag_value) ? PH_ADDR : PH_HUNT;
        endcase
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // transfer monitor: config, results, and prediction on input acceptance
    always @(posedge aclk) begin
        result_t   got;
        result_t   want;
        result_t   predicted;
        stim_row_t pin;
        logic      emits;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FLAG:    rx_cfg.flag_value = cfg_data;
                    REG_ESCAPE:  rx_cfg.escape_value = cfg_data;
                    REG_MASK:    rx_cfg.stuff_mask = cfg_data;
                    REG_ADDRESS: rx_cfg.address_value = cfg_data;
                    REG_CTRL0:   rx_cfg.ctrl_seq0 = cfg_data;
                    REG_CTRL1:   rx_cfg.ctrl_seq1 = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_kind = m_axis_tuser;
                got.data_byte = m_axis_tdata[7:0];
                got.seq_number = m_axis_tdata[8];
                got.reply_is_reject = m_axis_tdata[9];
                got.reply_number = m_axis_tdata[10];
                if (frame_results_due.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.out_kind != want.out_kind)
                        report_mismatch("out_kind", got.out_kind, want.out_kind);
                    if (got.data_byte != want.data_byte)
                        report_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.seq_number != want.seq_number)
                        report_mismatch("seq_number", got.seq_number, want.seq_number);
                    if (got.reply_is_reject != want.reply_is_reject)
                        report_mismatch("reply_is_reject", got.reply_is_reject,
                                        want.reply_is_reject);
                    if (got.reply_number != want.reply_number)
                        report_mismatch("reply_number", got.reply_number, want.reply_number);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pin = rx_pins.pop_front();
                emits = deframe_rx(s_axis_tdata, predicted);
                if (pin.pinned)
                    frame_results_due.push_back(pin.want);
                else if (emits)
                    frame_results_due.push_back(predicted);
            end
        end
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_rx(input logic [7:0] b, input logic pinned, input result_t want);
        stim_row_t pin;
        pin.rx = b;
        pin.pinned = pinned;
        pin.want = want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        rx_pins.push_back(pin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_results_due.size() != 0)
            @(posedge aclk);
        // an ignored byte may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input int ph);
        cfg_t c;
        case (ph)
            1: c = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h80};
            2: c = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h5A, 8'h5A};   // equal control bytes
            3: c = '{8'h81, 8'h81, 8'h01, 8'h7E, 8'h01, 8'h02};   // escape equals flag
            7: c = '{RST_FLAG, RST_ESCAPE, RST_MASK, RST_ADDRESS, RST_CTRL0, RST_CTRL1};
            default: c = cfg_t'({$urandom, 16'($urandom)});
        endcase
        write_reg(REG_FLAG, c.flag_value);
        write_reg(REG_ESCAPE, c.escape_value);
        write_reg(REG_MASK, c.stuff_mask);
        write_reg(REG_ADDRESS, c.address_value);
        write_reg(REG_CTRL0, c.ctrl_seq0);
        write_reg(REG_CTRL1, c.ctrl_seq1);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 5))
            0: return rx_cfg.flag_value;
            1: return rx_cfg.escape_value;
            2: return rx_cfg.address_value;
            3: return rx_cfg.ctrl_seq0;
            4: return rx_cfg.ctrl_seq1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stuff_byte(input logic [7:0] v);
        if (v == rx_cfg.flag_value || v == rx_cfg.escape_value) begin
            line_bytes.push_back(rx_cfg.escape_value);
            line_bytes.push_back(v ^ rx_cfg.stuff_mask);
        end else begin
            line_bytes.push_back(v);
        end
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            push_rx(line_bytes[i], 1'b0, NO_RESULT);
        line_bytes.delete();
    endtask

    // frame with random payload and a BCC2 that is sometimes wrong; corrupt hits one random byte
    task automatic send_frame(input int plen, input logic corrupt);
        logic [7:0] ctrl;
        logic [7:0] bcc2;
        logic [7:0] v;
        ctrl = $urandom_range(0, 1) ? rx_cfg.ctrl_seq1 : rx_cfg.ctrl_seq0;
        line_bytes.push_back(rx_cfg.flag_value);
        if ($urandom_range(0, 9) == 0)
            line_bytes.push_back(rx_cfg.flag_value);
        line_bytes.push_back(rx_cfg.address_value);
        line_bytes.push_back(ctrl);
        line_bytes.push_back(rx_cfg.address_value ^ ctrl);
        bcc2 = XOR_INIT;
        for (int i = 0; i < plen; i++) begin
            v = ($urandom_range(0, 3) == 0) ? pick_special() : 8'($urandom_range(0, 255));
            bcc2 ^= v;
            stuff_byte(v);
        end
        if ($urandom_range(0, 4) == 0)
            bcc2 ^= 8'($urandom_range(1, 255));
        stuff_byte(bcc2);
        line_bytes.push_back(rx_cfg.flag_value);
        if (corrupt)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        send_line();
    endtask

    initial begin
        int pick;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        // reset settings: flag 7E, escape 7D, mask 20, address 03, control 00 / 40
        directed_rows = '{
            '{8'h00, 1'b0, NO_RESULT},      // noise while hunting
            '{8'h7E, 1'b0, NO_RESULT},
            '{8'h7E, 1'b0, NO_RESULT},      // repeated flag
            '{8'h03, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, NO_RESULT},      // sequence 0
            '{8'h03, 1'b0, NO_RESULT},      // BCC1
            '{8'h7E, 1'b0, NO_RESULT},      // flag before any body byte
            '{8'h7D, 1'b0, NO_RESULT},
            '{8'h7E, 1'b0, NO_RESULT},      // drops the pending escape
            '{8'h00, 1'b0, NO_RESULT},
            '{8'h7D, 1'b0, NO_RESULT},
            '{8'h5E, 1'b1, '{KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b0}},
            '{8'h7D, 1'b0, NO_RESULT},
            '{8'h7D, 1'b1, '{KIND_DATA, 8'h7E, 1'b0, 1'b0, 1'b0}},  // escape after escape
            '{8'hFF, 1'b1, '{KIND_DATA, 8'h5D, 1'b0, 1'b0, 1'b0}},
            '{8'hDC, 1'b1, '{KIND_DATA, 8'hFF, 1'b0, 1'b0, 1'b0}},
            '{8'h7E, 1'b1, '{KIND_GOOD, 8'h00, 1'b0, 1'b0, 1'b1}},
            '{8'h03, 1'b0, NO_RESULT},      // closing flag opened the next frame
            '{8'h40, 1'b0, NO_RESULT},      // sequence 1
            '{8'h43, 1'b0, NO_RESULT},
            '{8'h11, 1'b0, NO_RESULT},
            '{8'h7D, 1'b0, NO_RESULT},
            '{8'h7E, 1'b1, '{KIND_BCC_ERR, 8'h00, 1'b1, 1'b1, 1'b1}},
            '{8'h05, 1'b0, NO_RESULT},      // bad address
            '{8'h7E, 1'b0, NO_RESULT},
            '{8'h03, 1'b0, NO_RESULT},
            '{8'h7E, 1'b0, NO_RESULT},      // flag as control byte
            '{8'h03, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, NO_RESULT},
            '{8'h55, 1'b0, NO_RESULT}       // bad BCC1
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            push_rx(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph != 0)
                apply_setting(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 75; end
                default: begin send_idle_pct = 31; recv_stall_pct <= 31; end
            endcase
            if (ph == 0) begin
                // long result hold-off while a long frame keeps coming in
                hold_seq <= hold_seq + 1;
                send_frame(40, 1'b0);
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                          : $urandom_range(0, 8), 1'b0);
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 6)) line_bytes.push_back(pick_special());
                    send_line();
                end else begin
                    send_frame($urandom_range(0, 6), 1'b1);
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ifdc_pkg.sv
rtl/ifdc_cfg.sv
rtl/ifdc_core.sv
rtl/ifdc_out_reg.sv
rtl/info_frame_deframer_checker.sv
rtl/ifdc_checker.sv
tb/tb_info_frame_deframer_checker.sv
